// ----- sv/cde_pkg.sv -----
package cde_pkg;

    localparam int YS_W         = 13;
    localparam int PROD_W       = 26;
    localparam int DIV100_SHIFT = 19;
    localparam int Q_W          = PROD_W - DIV100_SHIFT;
    localparam int ORD_W        = 21;
    localparam int DATE_W       = 21;

    localparam logic [YS_W-1:0] DIV100_MUL = 13'd5243;
    localparam logic [YS_W-1:0] YEAR_BIAS  = 13'd399;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [1:0] ORD_EQUAL   = 2'd0;
    localparam logic [1:0] ORD_EARLIER = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    typedef struct packed {
        logic [5:0]  in_day;
        logic [3:0]  in_month;
        logic [11:0] in_year;
        logic [4:0]  other_day;
        logic [3:0]  other_month;
        logic [11:0] other_year;
        logic [3:0]  query_month;
    } cde_in_t;

    typedef struct packed {
        logic [DATE_W-1:0] fixed_date;
        logic              was_corrected;
        logic              is_leap;
        logic [4:0]        query_days;
        logic [DATE_W-1:0] next_date;
        logic              next_over;
        logic [DATE_W-1:0] prev_date;
        logic              prev_under;
        logic [15:0]       days_since_base;
        logic [15:0]       days_apart;
        logic [2:0]        weekday;
        logic [1:0]        order;
    } cde_out_t;

    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [11:0]       year;
        logic              corr;
        logic [4:0]        other_day;
        logic [3:0]        other_month_raw;
        logic [3:0]        other_month;
        logic [11:0]       other_year;
        logic [3:0]        query_month;
        logic [PROD_W-1:0] main_prod;
        logic [PROD_W-1:0] main_ys_prod;
        logic [PROD_W-1:0] other_prod;
        logic [PROD_W-1:0] other_ys_prod;
    } cde_s1_t;

    typedef struct packed {
        logic [4:0]       day;
        logic [3:0]       month;
        logic [11:0]      year;
        logic             corr;
        logic             leap;
        logic [ORD_W-1:0] main_year_days;
        logic [4:0]       other_day;
        logic [3:0]       other_month_raw;
        logic [3:0]       other_month;
        logic [11:0]      other_year;
        logic             other_leap;
        logic [ORD_W-1:0] other_year_days;
        logic [3:0]       query_month;
    } cde_s2_t;

    typedef struct packed {
        logic [DATE_W-1:0] fixed_date;
        logic              was_corrected;
        logic              is_leap;
        logic [4:0]        query_days;
        logic [DATE_W-1:0] next_date;
        logic              next_over;
        logic [DATE_W-1:0] prev_date;
        logic              prev_under;
        logic [1:0]        order;
        logic [ORD_W-1:0]  main_ord;
        logic [ORD_W-1:0]  other_ord;
    } cde_s3_t;

    function automatic logic leap_of(input logic [11:0] year, input logic [Q_W-1:0] q100);
        logic [YS_W-1:0] hundreds;
        hundreds = YS_W'(q100) * YS_W'(100);
        return (year[1:0] == 2'b00) &&
               (({1'b0, year} != hundreds) || (q100[1:0] == 2'b00));
    endfunction

    function automatic logic [ORD_W-1:0] year_days(input logic [YS_W-1:0] ys,
                                                   input logic [Q_W-1:0] q100);
        return ORD_W'(ys) * ORD_W'(365) + ORD_W'(ys[YS_W-1:2])
               - ORD_W'(q100) + ORD_W'(q100[Q_W-1:2]);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        unique case (month)
            MONTH_FEB:                 n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] n;
        unique case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DATE_W-1:0] pack_date(input logic [4:0] day,
                                                    input logic [3:0] month,
                                                    input logic [11:0] year);
        return {year, month, day};
    endfunction

endpackage

// ----- sv/cde_prep.sv -----
module cde_prep import cde_pkg::*; #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 2050
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cde_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cde_s1_t out_data
);

    logic            valid_reg;
    cde_s1_t         data_reg;
    cde_s1_t         data_next;
    logic            day_ok;
    logic            month_ok;
    logic            year_ok;
    logic [11:0]     year_fix;
    logic [YS_W-1:0] main_ys;
    logic [YS_W-1:0] other_ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        day_ok   = (in_data.in_day[5] == 1'b0) && (in_data.in_day[4:0] != 5'd0);
        month_ok = (in_data.in_month != 4'd0) && (in_data.in_month <= MONTH_DEC);
        year_ok  = ({1'b0, in_data.in_year} >= YS_W'(MIN_YEAR)) &&
                   ({1'b0, in_data.in_year} <= YS_W'(MAX_YEAR));
        year_fix = year_ok ? in_data.in_year : 12'(MIN_YEAR);
        main_ys  = {1'b0, year_fix} + YEAR_BIAS;
        other_ys = {1'b0, in_data.other_year} + YEAR_BIAS;

        data_next.day             = day_ok ? in_data.in_day[4:0] : 5'd1;
        data_next.month           = month_ok ? in_data.in_month : MONTH_JAN;
        data_next.year            = year_fix;
        data_next.corr            = !day_ok || !month_ok || !year_ok;
        data_next.other_day       = in_data.other_day;
        data_next.other_month_raw = in_data.other_month;
        data_next.other_month     = ((in_data.other_month != 4'd0) &&
                                     (in_data.other_month <= MONTH_DEC)) ?
                                    in_data.other_month : MONTH_JAN;
        data_next.other_year      = in_data.other_year;
        data_next.query_month     = ((in_data.query_month != 4'd0) &&
                                     (in_data.query_month <= MONTH_DEC)) ?
                                    in_data.query_month : MONTH_JAN;
        data_next.main_prod       = PROD_W'({1'b0, year_fix}) * PROD_W'(DIV100_MUL);
        data_next.main_ys_prod    = PROD_W'(main_ys) * PROD_W'(DIV100_MUL);
        data_next.other_prod      = PROD_W'({1'b0, in_data.other_year}) * PROD_W'(DIV100_MUL);
        data_next.other_ys_prod   = PROD_W'(other_ys) * PROD_W'(DIV100_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/cde_year.sv -----
module cde_year import cde_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cde_s1_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cde_s2_t out_data
);

    logic           valid_reg;
    cde_s2_t        data_reg;
    cde_s2_t        data_next;
    logic           main_leap;
    logic [4:0]     main_dim;
    logic           too_big;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        main_leap = leap_of(in_data.year, in_data.main_prod[PROD_W-1:DIV100_SHIFT]);
        main_dim  = days_in(in_data.month, main_leap);
        too_big   = in_data.day > main_dim;

        data_next.day             = in_data.day;
        data_next.month           = too_big ? MONTH_JAN : in_data.month;
        data_next.year            = in_data.year;
        data_next.corr            = in_data.corr || too_big;
        data_next.leap            = main_leap;
        data_next.main_year_days  = year_days({1'b0, in_data.year} + YEAR_BIAS,
                                              in_data.main_ys_prod[PROD_W-1:DIV100_SHIFT]);
        data_next.other_day       = in_data.other_day;
        data_next.other_month_raw = in_data.other_month_raw;
        data_next.other_month     = in_data.other_month;
        data_next.other_year      = in_data.other_year;
        data_next.other_leap      = leap_of(in_data.other_year,
                                            in_data.other_prod[PROD_W-1:DIV100_SHIFT]);
        data_next.other_year_days = year_days({1'b0, in_data.other_year} + YEAR_BIAS,
                                              in_data.other_ys_prod[PROD_W-1:DIV100_SHIFT]);
        data_next.query_month     = in_data.query_month;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/cde_date.sv -----
module cde_date import cde_pkg::*; #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 2050
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cde_s2_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cde_s3_t out_data
);

    logic              valid_reg;
    cde_s3_t           data_reg;
    cde_s3_t           data_next;
    logic [4:0]        dim;
    logic              last_day;
    logic              year_end;
    logic [4:0]        next_day;
    logic [3:0]        next_month;
    logic [YS_W-1:0]   next_year;
    logic              over;
    logic              first_day;
    logic              year_start;
    logic [4:0]        prev_day;
    logic [3:0]        prev_month;
    logic [11:0]       prev_year;
    logic              under;
    logic [DATE_W-1:0] fixed;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        fixed = pack_date(in_data.day, in_data.month, in_data.year);
        dim   = days_in(in_data.month, in_data.leap);

        // next day
        last_day   = in_data.day == dim;
        year_end   = last_day && (in_data.month == MONTH_DEC);
        next_day   = last_day ? 5'd1 : 5'(in_data.day + 5'd1);
        next_month = year_end ? MONTH_JAN :
                     (last_day ? 4'(in_data.month + 4'd1) : in_data.month);
        next_year  = year_end ? ({1'b0, in_data.year} + YS_W'(1)) : {1'b0, in_data.year};
        over       = next_year > YS_W'(MAX_YEAR);

        // previous day
        first_day  = in_data.day == 5'd1;
        year_start = first_day && (in_data.month == MONTH_JAN);
        prev_month = year_start ? MONTH_DEC :
                     (first_day ? 4'(in_data.month - 4'd1) : in_data.month);
        prev_year  = year_start ? 12'(in_data.year - 12'd1) : in_data.year;
        prev_day   = first_day ? days_in(prev_month, in_data.leap) : 5'(in_data.day - 5'd1);
        under      = year_start && ({1'b0, in_data.year} <= YS_W'(MIN_YEAR));

        data_next.fixed_date    = fixed;
        data_next.was_corrected = in_data.corr;
        data_next.is_leap       = in_data.leap;
        data_next.query_days    = days_in(in_data.query_month, in_data.leap);
        data_next.next_date     = over ? fixed :
                                  pack_date(next_day, next_month, next_year[11:0]);
        data_next.next_over     = over;
        data_next.prev_date     = under ? fixed : pack_date(prev_day, prev_month, prev_year);
        data_next.prev_under    = under;

        priority if (in_data.year != in_data.other_year) begin
            data_next.order = (in_data.year < in_data.other_year) ? ORD_EARLIER : ORD_LATER;
        end else if (in_data.month != in_data.other_month_raw) begin
            data_next.order = (in_data.month < in_data.other_month_raw) ? ORD_EARLIER
                                                                        : ORD_LATER;
        end else if (in_data.day != in_data.other_day) begin
            data_next.order = (in_data.day < in_data.other_day) ? ORD_EARLIER : ORD_LATER;
        end else begin
            data_next.order = ORD_EQUAL;
        end

        data_next.main_ord  = in_data.main_year_days + ORD_W'(cum_days(in_data.month))
                              + ORD_W'((in_data.month > MONTH_FEB) && in_data.leap)
                              + ORD_W'(in_data.day);
        data_next.other_ord = in_data.other_year_days + ORD_W'(cum_days(in_data.other_month))
                              + ORD_W'((in_data.other_month > MONTH_FEB) && in_data.other_leap)
                              + ORD_W'(in_data.other_day);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/cde_dist.sv -----
module cde_dist import cde_pkg::*; #(
    parameter int MIN_YEAR = 1900
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  cde_s3_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cde_out_t out_data
);

    localparam int BASE_YS  = MIN_YEAR + 399;
    localparam int BASE_ORD = BASE_YS * 365 + BASE_YS / 4 - BASE_YS / 100 + BASE_YS / 400 + 1;
    localparam int CHUNKS   = ORD_W / 3;

    logic             valid_reg;
    cde_out_t         data_reg;
    cde_out_t         data_next;
    logic [ORD_W-1:0] since;
    logic [ORD_W-1:0] apart;
    logic [5:0]       fold1;
    logic [3:0]       fold2;
    logic [3:0]       wd;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        since = in_data.main_ord - ORD_W'(BASE_ORD);
        apart = (in_data.main_ord >= in_data.other_ord) ?
                (in_data.main_ord - in_data.other_ord) :
                (in_data.other_ord - in_data.main_ord);

        // day number mod 7, folding octal digits since 8 is 1 mod 7
        fold1 = '0;
        for (int i = 0; i < CHUNKS; i++) begin
            fold1 = fold1 + 6'(in_data.main_ord[3*i +: 3]);
        end
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        wd    = (fold2 >= 4'd7) ? 4'(fold2 - 4'd7) : fold2;

        data_next.fixed_date      = in_data.fixed_date;
        data_next.was_corrected   = in_data.was_corrected;
        data_next.is_leap         = in_data.is_leap;
        data_next.query_days      = in_data.query_days;
        data_next.next_date       = in_data.next_date;
        data_next.next_over       = in_data.next_over;
        data_next.prev_date       = in_data.prev_date;
        data_next.prev_under      = in_data.prev_under;
        data_next.days_since_base = (|since[ORD_W-1:16]) ? 16'hFFFF : since[15:0];
        data_next.days_apart      = (|apart[ORD_W-1:16]) ? 16'hFFFF : apart[15:0];
        data_next.weekday         = wd[2:0];
        data_next.order           = in_data.order;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- sv/calendar_date_engine_core.sv -----
// throughput: one item per cycle while m_ready stays high, through four register stages
// (range clamp and divide-by-100 products, leap and year days, date steps, distances)
// each stage holds its item while the next one is full and stalled
// reset: synchronous active-low aresetn clears all stage valid bits; payload is not reset
module calendar_date_engine_core import cde_pkg::*; #(
    parameter int MIN_YEAR = 1900,
    parameter int MAX_YEAR = 2050
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cde_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cde_out_t m_data
);

    logic    s1_valid;
    logic    s1_ready;
    cde_s1_t s1_data;
    logic    s2_valid;
    logic    s2_ready;
    cde_s2_t s2_data;
    logic    s3_valid;
    logic    s3_ready;
    cde_s3_t s3_data;

    cde_prep #(
        .MIN_YEAR (MIN_YEAR),
        .MAX_YEAR (MAX_YEAR)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    cde_year u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    cde_date #(
        .MIN_YEAR (MIN_YEAR),
        .MAX_YEAR (MAX_YEAR)
    ) u_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    cde_dist #(
        .MIN_YEAR (MIN_YEAR)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTHESIS
    a_equal_zero_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.order == ORD_EQUAL) |-> m_data.days_apart == 16'd0)
        else $error("equal dates with nonzero distance");

    a_over_at_year_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.next_over |->
            (m_data.fixed_date[8:5] == MONTH_DEC) && (m_data.fixed_date[4:0] == 5'd31))
        else $error("next_over away from last day of year");

    a_under_at_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.prev_under |->
            (m_data.days_since_base == 16'd0) && (m_data.fixed_date[8:5] == MONTH_JAN))
        else $error("prev_under away from base date");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.weekday != 3'd7)
        else $error("weekday out of range");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid && !s3_ready |=> s3_valid && $stable(s3_data))
        else $error("stalled stage item changed");
`endif

endmodule
